// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Every use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Types and constants shared by the pattern masker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

  // Largest pattern the window can hold, in bytes.
  localparam int MAX_PATTERN = 16;
  localparam int CNT_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int WIN_W       = 8 * MAX_PATTERN;

  // Byte that replaces every masked input byte.
  localparam logic [7:0] STAR_BYTE = 8'd42;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } out_word_t;

  // Pattern bytes (byte 0 in the low bits) and the clamped length.
  typedef struct packed {
    logic [WIN_W-1:0] pattern;
    logic [LEN_W-1:0] len;
  } cfg_t;

  // One word's worth of output work: the first lit_cnt bytes of the window
  // go out as literals, the rest up to last_idx as stars.
  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [LEN_W-1:0] lit_cnt;
    logic [CNT_W-1:0] last_idx;
    logic             eos;
  } job_t;

endpackage

`default_nettype wire

// ===== design/spm_front.sv =====
// ----------------------------------------------------------------------------
// spm_front
// Accepts input words, keeps the pending window and turns each word into an
// output job (literal count, star count, end of stream).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spm_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spm_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spm_pkg::in_word_t  in_data,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output spm_pkg::job_t           push_job
);

  logic [spm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [spm_pkg::WIN_W-1:0] win_r, win_nxt;
  logic [spm_pkg::WIN_W-1:0] win_app;
  logic [spm_pkg::WIN_W-1:0] win_shift;
  logic [spm_pkg::LEN_W-1:0] c_app;
  logic [spm_pkg::LEN_W-1:0] excess;
  logic [spm_pkg::LEN_W-1:0] lit_cnt;
  logic [spm_pkg::LEN_W-1:0] star_cnt;
  logic [spm_pkg::LEN_W-1:0] total;
  logic                      full;
  logic                      match_ok;
  logic                      match;
  logic                      in_acc;

  assign in_ready = push_ready;
  assign in_acc   = in_valid && in_ready;

  // Append the new word at the fill position.
  always_comb begin
    for (int i = 0; i < spm_pkg::MAX_PATTERN; i++) begin
      win_app[i*8 +: 8] = (spm_pkg::CNT_W'(i) == cnt_r) ? in_data.data_byte
                                                         : win_r[i*8 +: 8];
    end
  end

  // Drop bytes beyond the pattern length, then compare with the pattern.
  always_comb begin
    c_app     = spm_pkg::LEN_W'(cnt_r) + spm_pkg::LEN_W'(1);
    full      = (c_app >= cfg.len);
    excess    = full ? (c_app - cfg.len) : '0;
    win_shift = win_app >> {excess, 3'b000};
    match_ok  = 1'b1;
    for (int i = 0; i < spm_pkg::MAX_PATTERN; i++) begin
      if ((spm_pkg::LEN_W'(i) < cfg.len) &&
          (win_shift[i*8 +: 8] != cfg.pattern[i*8 +: 8])) begin
        match_ok = 1'b0;
      end
    end
    match = full && match_ok;
  end

  // Classify the word: how many literals and stars it releases.
  always_comb begin
    if (match) begin
      lit_cnt  = excess;
      star_cnt = cfg.len;
    end else if (in_data.end_of_stream) begin
      lit_cnt  = c_app;
      star_cnt = '0;
    end else if (full) begin
      lit_cnt  = excess + spm_pkg::LEN_W'(1);
      star_cnt = '0;
    end else begin
      lit_cnt  = '0;
      star_cnt = '0;
    end
    total = lit_cnt + star_cnt;

    push_job.window   = win_app;
    push_job.lit_cnt  = lit_cnt;
    push_job.last_idx = spm_pkg::CNT_W'(total - spm_pkg::LEN_W'(1));
    push_job.eos      = in_data.end_of_stream;
    push_valid        = in_acc && (total != '0);
  end

  // Window contents and fill count after this word.
  always_comb begin
    win_nxt = full ? (win_shift >> 8) : win_shift;
    if (in_data.end_of_stream || match) begin
      cnt_nxt = '0;
    end else if (full) begin
      cnt_nxt = spm_pkg::CNT_W'(cfg.len - spm_pkg::LEN_W'(1));
    end else begin
      cnt_nxt = spm_pkg::CNT_W'(c_app);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Window bytes above the fill count are never read, so no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r <= win_nxt;
    end
  end

  // The end of a stream always leaves the window empty.
  `SPM_ASSERT_NEXT(a_eos_empties, in_acc && in_data.end_of_stream, cnt_r == '0)
  // A word never releases more literals than the bytes it has pending.
  `SPM_ASSERT_SAME(a_lit_bound, in_acc, lit_cnt <= c_app)

endmodule

`default_nettype wire

// ===== design/spm_queue.sv =====
// ----------------------------------------------------------------------------
// spm_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire spm_pkg::job_t  push_job,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output spm_pkg::job_t       pop_job
);

  spm_pkg::job_t entry_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers agree with the fill level.
  `SPM_ASSERT_SAME(a_ptr_level, cnt_r == 2'd0 || cnt_r == 2'd2, wr_ptr_r == rd_ptr_r)

endmodule

`default_nettype wire

// ===== design/spm_back.sv =====
// ----------------------------------------------------------------------------
// spm_back
// Walks the head job into the output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire spm_pkg::job_t   pop_job,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output spm_pkg::out_word_t   out_data
);

  logic [spm_pkg::CNT_W-1:0] idx_r;
  logic                      out_valid_r;
  spm_pkg::out_word_t        out_data_r, out_data_nxt;
  logic                      load;
  logic                      is_last;

  assign load      = pop_valid && (!out_valid_r || out_ready);
  assign is_last   = (idx_r == pop_job.last_idx);
  assign pop_ready = load && is_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Literal from the window, or a star once the literals are used up.
  always_comb begin
    if (spm_pkg::LEN_W'(idx_r) < pop_job.lit_cnt) begin
      out_data_nxt.out_byte = pop_job.window[idx_r*8 +: 8];
    end else begin
      out_data_nxt.out_byte = spm_pkg::STAR_BYTE;
    end
    out_data_nxt.run_last    = is_last;
    out_data_nxt.stream_done = is_last && pop_job.eos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? '0 : idx_r + spm_pkg::CNT_W'(1);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // The end of a stream is always the last result of its word.
  `SPM_ASSERT_SAME(a_done_is_last, out_valid_r && out_data_r.stream_done, out_data_r.run_last)

endmodule

`default_nettype wire

// ===== design/stream_pattern_masker.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_masker
// Copies a byte stream and replaces each leftmost, non-overlapping occurrence
// of a 1 to 16 byte pattern by the same number of star bytes.
// ----------------------------------------------------------------------------
// The block takes one input word per cycle while in_ready is high and
// delivers one result word per cycle while out_ready is high. The front end
// classifies each word in the cycle it is accepted and hands a job to a
// two-entry queue; the back end reads the job from its queue entry and emits
// its results through an output register. A word that causes no result hands
// no job to the queue; a word that completes a match, or ends the stream,
// produces up to 16 results. Input ready drops only while the queue holds two
// pending jobs. Configuration is written directly with cfg_we and takes effect
// on the next accepted word.
`timescale 1ns / 1ps
`default_nettype none

module stream_pattern_masker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [63:0]                       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire spm_pkg::in_word_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output spm_pkg::out_word_t                     out_data
);

  logic [63:0]               pat_low_r;
  logic [63:0]               pat_high_r;
  logic [4:0]                pat_len_r;
  logic [spm_pkg::LEN_W-1:0] eff_len;
  spm_pkg::cfg_t             cfg;
  logic                      push_valid;
  logic                      push_ready;
  spm_pkg::job_t             push_job;
  logic                      pop_valid;
  logic                      pop_ready;
  spm_pkg::job_t             pop_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        spm_pkg::CFG_PAT_LOW:  pat_low_r  <= cfg_data;
        spm_pkg::CFG_PAT_HIGH: pat_high_r <= cfg_data;
        spm_pkg::CFG_PAT_LEN:  pat_len_r  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the length to the window size; zero counts as one.
  always_comb begin
    if (pat_len_r == 5'd0) begin
      eff_len = spm_pkg::LEN_W'(1);
    end else if (spm_pkg::LEN_W'(pat_len_r) > spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN)) begin
      eff_len = spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN);
    end else begin
      eff_len = spm_pkg::LEN_W'(pat_len_r);
    end
    cfg.pattern = {pat_high_r, pat_low_r};
    cfg.len     = eff_len;
  end

  spm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  spm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  spm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/stream_pattern_masker_test.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_masker_test
// Self-checking bench for the pattern masker. Byte words are streamed in
// through the valid/ready input while a local model of the masking window
// predicts each result word, checked field by field against the oldest
// prediction. Pattern and length registers change between phases while the
// block is idle; both sides stall at random until the fifth random phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_pattern_masker_test;

  // Index 3 decodes to no register and must be ignored.
  localparam logic [spm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index = spm_pkg::CFG_PAT_LOW;
  logic [63:0]                   cfg_data  = 64'd0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  spm_pkg::in_word_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  spm_pkg::out_word_t            out_data;

  // Model copy of the registers and of the pending window.
  logic [63:0] pat_low_reg  = 64'd0;
  logic [63:0] pat_high_reg = 64'd0;
  logic [4:0]  pat_len_reg  = 5'd1;
  logic [7:0]  byte_window [spm_pkg::MAX_PATTERN];
  int          window_fill  = 0;

  spm_pkg::in_word_t  stream_words[$];
  spm_pkg::out_word_t predicted_words[$];

  int send_idle_pct = 16;
  int recv_idle_pct = 54;
  int error_count   = 0;

  stream_pattern_masker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Pattern length as the block uses it: zero means one, large values clamp.
  function automatic int effective_length();
    int len;
    len = int'(pat_len_reg);
    if (len < 1) len = 1;
    if (len > spm_pkg::MAX_PATTERN) len = spm_pkg::MAX_PATTERN;
    return len;
  endfunction

  function automatic logic [7:0] pattern_byte(input int pos);
    logic [127:0] all_bytes;
    all_bytes = {pat_high_reg, pat_low_reg};
    return all_bytes[8*pos +: 8];
  endfunction

  // Send the oldest pending byte out as a literal and shift the window.
  task automatic release_oldest();
    spm_pkg::out_word_t lit;
    if (window_fill == 0) return;
    lit = '{byte_window[0], 1'b0, 1'b0};
    predicted_words.push_back(lit);
    for (int i = 0; i < spm_pkg::MAX_PATTERN - 1; i++) byte_window[i] = byte_window[i + 1];
    window_fill--;
  endtask

  // Work out every result word that one accepted input word causes.
  task automatic predict_masking(input spm_pkg::in_word_t w);
    int                 len;
    int                 first;
    bit                 hit;
    spm_pkg::out_word_t tail;
    spm_pkg::out_word_t star;
    len   = effective_length();
    first = predicted_words.size();
    star  = '{spm_pkg::STAR_BYTE, 1'b0, 1'b0};
    if (window_fill >= spm_pkg::MAX_PATTERN) release_oldest();
    byte_window[window_fill] = w.data_byte;
    window_fill++;
    // A length that shrank since the last word pushes the excess out first.
    while (window_fill > len) release_oldest();
    if (window_fill == len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (byte_window[i] != pattern_byte(i)) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < len; i++) predicted_words.push_back(star);
        window_fill = 0;
      end else begin
        release_oldest();
      end
    end
    if (w.end_of_stream) begin
      while (window_fill > 0) release_oldest();
    end
    // Tag the last word of this run, and of the stream on a flush.
    if (predicted_words.size() > first) begin
      tail = predicted_words.pop_back();
      tail.run_last    = 1'b1;
      tail.stream_done = w.end_of_stream;
      predicted_words.push_back(tail);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Input driver: predicts on each accepted word, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_masking(in_data);
      if (!in_valid || in_ready) begin
        if (stream_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= stream_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted result word, then picks the next ready.
  always @(posedge clk) begin
    spm_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_words.size() == 0) begin
        report_mismatch("unexpected word", int'(out_data), 0);
      end else begin
        want = predicted_words.pop_front();
        if (out_data.out_byte != want.out_byte)
          report_mismatch("out_byte", int'(out_data.out_byte), int'(want.out_byte));
        if (out_data.run_last != want.run_last)
          report_mismatch("run_last", int'(out_data.run_last), int'(want.run_last));
        if (out_data.stream_done != want.stream_done)
          report_mismatch("stream_done", int'(out_data.stream_done),
                          int'(want.stream_done));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Register write; the model copy follows at once since the block is idle.
  task automatic write_reg(input logic [spm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      spm_pkg::CFG_PAT_LOW:  pat_low_reg  = value;
      spm_pkg::CFG_PAT_HIGH: pat_high_reg = value;
      spm_pkg::CFG_PAT_LEN:  pat_len_reg  = value[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit eos);
    spm_pkg::in_word_t w;
    w.data_byte     = b;
    w.end_of_stream = eos;
    stream_words.push_back(w);
  endtask

  // Random stream made of whole patterns, pattern prefixes and stray bytes.
  task automatic queue_segment(input int n);
    int added;
    int len;
    int cut;
    added = 0;
    len   = effective_length();
    while (added < n) begin
      case ($urandom_range(5))
        0, 1:    cut = len;
        2:       cut = int'($urandom_range(len - 1));
        default: cut = 0;
      endcase
      if (cut == 0) begin
        queue_byte(8'($urandom_range(255)), $urandom_range(11) == 0);
        added++;
      end else begin
        for (int i = 0; i < cut; i++) begin
          queue_byte(pattern_byte(i), $urandom_range(11) == 0);
          added++;
        end
      end
    end
  endtask

  // Wait until every word is sent and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (stream_words.size() != 0 || in_valid || predicted_words.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [63:0] len_raw;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Pattern "abc" with a false start and a partial match flushed at the end.
    write_reg(spm_pkg::CFG_PAT_LOW, 64'h0000_0000_0063_6261);
    write_reg(spm_pkg::CFG_PAT_LEN, 64'd3);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h63, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b1);
    wait_drained();

    // Full 16-byte pattern that completes on the end-of-stream word.
    write_reg(spm_pkg::CFG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(spm_pkg::CFG_PAT_HIGH, 64'h8000_0000_0000_0000);
    write_reg(spm_pkg::CFG_PAT_LEN, 64'd16);
    for (int i = 0; i < spm_pkg::MAX_PATTERN; i++)
      queue_byte(pattern_byte(i), i == spm_pkg::MAX_PATTERN - 1);
    wait_drained();

    // Oversized length clamps to 16; a write to the unmapped index is ignored.
    write_reg(spm_pkg::CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_UNMAPPED, 64'hA5A5_5A5A_0F0F_F0F0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h33, 1'b0);
    wait_drained();

    // Length zero acts as one and shrinks the window mid-stream; NUL is masked.
    write_reg(spm_pkg::CFG_PAT_LOW, 64'd0);
    write_reg(spm_pkg::CFG_PAT_LEN, 64'd0);
    queue_byte(8'h00, 1'b1);
    wait_drained();

    // Random phases, each with a fresh pattern and length.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 54;
        recv_idle_pct = 16;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(spm_pkg::CFG_PAT_LOW, {$urandom, $urandom});
      write_reg(spm_pkg::CFG_PAT_HIGH, {$urandom, $urandom});
      if (seg == 1) begin
        len_raw = 64'd16;
      end else if (seg == 3) begin
        len_raw = 64'd1;
      end else if ($urandom_range(3) == 0) begin
        len_raw = {$urandom, $urandom};
      end else begin
        len_raw = 64'($urandom_range(5, 1));
      end
      write_reg(spm_pkg::CFG_PAT_LEN, len_raw);
      queue_segment(11);
      wait_drained();
    end

    // Close the stream so the window is flushed.
    queue_byte(8'($urandom_range(255)), 1'b1);
    wait_drained();
    repeat (16) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
